[hdl/deque_with_parity_sums_defines.svh]
// assertion macros for the deque rtl
`ifndef DEQUE_WITH_PARITY_SUMS_DEFINES_SVH
`define DEQUE_WITH_PARITY_SUMS_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DWPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DWPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

[hdl/dwps_pkg.sv]
// types and constants of the deque with parity sums
`timescale 1ns / 1ps
package dwps_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  // command codes; unused codes act as query
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [ENTRIES_W-1:0]     entries;
    logic signed [DATA_W-1:0] odd_position_sum;
    logic signed [DATA_W-1:0] even_position_sum;
  } rsp_t;

endpackage

[hdl/dwps_ram.sv]
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
module dwps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/deque_with_parity_sums.sv]
// top level of the bounded deque with odd and even position sums
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit entries held in a ring ram of
// DEPTH words. A command transfers at a rising edge where start is high and
// busy is low. Every command gives exactly one result on rsp_o, marked by
// rsp_valid_o for one cycle; the receiver cannot stall it, so it must take
// each result in that cycle. Pushes, queries, refused pushes and pops on an
// empty queue show their result the cycle after the transfer, and a new
// command may transfer in that same cycle. A pop on a non-empty queue goes
// through the registered ram read: busy is high in the cycle the read data
// returns, and the result shows the cycle after. The entry count reported is
// the low five bits of the occupancy. Both sums wrap modulo 2^32; a push or
// pop at the front swaps odd and even sums.
module deque_with_parity_sums
  import dwps_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

`include "deque_with_parity_sums_defines.svh"

  localparam int IW = $clog2(DEPTH);       // ring index width
  localparam int CW = $clog2(DEPTH + 1);   // occupancy width, holds DEPTH
  localparam int SW = CW + 1;              // index sum width before wrap

  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] WRAP_SUM = SW'(DEPTH);

  // control states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_q, state_d;
  logic pop_front_q, pop_front_d;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [DATA_W-1:0] odd_q, odd_d;
  logic [DATA_W-1:0] even_q, even_d;
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  logic accept;
  logic full, empty;
  logic [IW-1:0] front_inc, front_dec;
  logic [CW-1:0] offset;
  logic [SW-1:0] pos_sum;
  logic [IW-1:0] ring_idx;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] popped;
  logic [STATUS_W-1:0] status;

  assign accept = start && !busy;
  assign busy   = (state_q == S_POP);
  assign full   = (count_q == FULL_CNT);
  assign empty  = (count_q == '0);

  // neighbours of the front slot on the ring
  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;

  // back slot: the free one after the last entry for a push, the last entry
  // for a pop; front + offset stays below twice the depth, one subtract wraps
  assign offset   = (cmd_i.command == CMD_POP_BACK) ? count_q - 1'b1 : count_q;
  assign pos_sum  = SW'(front_q) + SW'(offset);
  assign ring_idx = (pos_sum >= WRAP_SUM) ? IW'(pos_sum - WRAP_SUM) : IW'(pos_sum);

  dwps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    pop_front_d = pop_front_q;
    front_d     = front_q;
    count_d     = count_q;
    odd_d       = odd_q;
    even_d      = even_q;
    rsp_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ring_idx;
    ram_raddr   = ring_idx;
    popped      = '0;
    status      = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_valid_d = 1'b1;
          unique case (cmd_i.command)
            CMD_PUSH_BACK: begin
              if (full) begin
                status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
                // new entry lands at position count+1
                if (!count_q[0]) begin
                  odd_d = odd_q + cmd_i.value;
                end else begin
                  even_d = even_q + cmd_i.value;
                end
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_d   = front_dec;
                count_d   = count_q + 1'b1;
                // every entry moves one position back
                odd_d     = even_q + cmd_i.value;
                even_d    = odd_q;
              end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
              if (empty) begin
                status = ST_EMPTY;
              end else begin
                // result waits for the ram read data
                rsp_valid_d = 1'b0;
                ram_re      = 1'b1;
                pop_front_d = (cmd_i.command == CMD_POP_FRONT);
                if (cmd_i.command == CMD_POP_FRONT) begin
                  ram_raddr = front_q;
                end
                state_d = S_POP;
              end
            end
            default: begin
              status = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        popped      = ram_rdata;
        rsp_valid_d = 1'b1;
        count_d     = count_q - 1'b1;
        if (pop_front_q) begin
          front_d = front_inc;
          odd_d   = even_q;
          even_d  = odd_q - ram_rdata;
        end else if (count_q[0]) begin
          odd_d = odd_q - ram_rdata;
        end else begin
          even_d = even_q - ram_rdata;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.popped_value      = popped;
    rsp_d.status            = status;
    rsp_d.entries           = ENTRIES_W'(count_d);
    rsp_d.odd_position_sum  = odd_d;
    rsp_d.even_position_sum = even_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pop_front_q <= 1'b0;
      front_q     <= '0;
      count_q     <= '0;
      odd_q       <= '0;
      even_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pop_front_q <= pop_front_d;
      front_q     <= front_d;
      count_q     <= count_d;
      odd_q       <= odd_d;
      even_q      <= even_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // result payload, only meaningful with the strobe
  always_ff @(posedge clk_i) begin
    if (rsp_valid_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // every transfer gives a result next cycle or goes into the pop read
  `DWPS_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, accept, rsp_valid_o || busy)
  // the pop read stage is left in the next cycle, which reports the result
  `DWPS_ASSERT_NEXT(a_pop_one_cycle, clk_i, rst_ni, busy, !busy && rsp_valid_o)
  // occupancy never exceeds the ring size
  `DWPS_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT)
  // a refused push is only reported with the ring full
  `DWPS_ASSERT_NOW(a_full_status, clk_i, rst_ni,
                   rsp_valid_o && rsp_o.status == ST_FULL, count_q == FULL_CNT)
  // an empty pop reports zero and leaves the ring empty
  `DWPS_ASSERT_NOW(a_empty_status, clk_i, rst_ni,
                   rsp_valid_o && rsp_o.status == ST_EMPTY,
                   rsp_o.popped_value == '0 && count_q == '0)

endmodule

[bench/tb_deque_with_parity_sums.sv]
// self-checking testbench for the bounded deque with odd and even position sums
`timescale 1ns / 1ps
module tb_deque_with_parity_sums;
  import dwps_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  // codes past query, decoded by the block as query
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int DRAIN_INTERVAL = 400;
  localparam int TAIL_CYCLES    = 8;

  // mirrors the deque contents and the two running sums, and keeps the
  // responses still owed by the block in command order
  class deque_scoreboard;
    logic [DATA_W-1:0] store [DEPTH];
    int unsigned       front_idx;
    int unsigned       count;
    logic [DATA_W-1:0] odd_sum;
    logic [DATA_W-1:0] even_sum;
    rsp_t              pending_rsp [$];
    int unsigned       errors;

    function new();
      front_idx = 0;
      count     = 0;
      odd_sum   = '0;
      even_sum  = '0;
      errors    = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function int unsigned outstanding();
      return pending_rsp.size();
    endfunction

    // advance the mirror by one accepted command and queue its response
    function void note_command(cmd_t c);
      rsp_t              r;
      logic [DATA_W-1:0] popped;
      logic [DATA_W-1:0] held;
      logic [STATUS_W-1:0] st;
      int unsigned       slot;
      popped = '0;
      st     = ST_OK;
      case (c.command)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            st = ST_FULL;
          end else if (c.command == CMD_PUSH_BACK) begin
            slot        = (front_idx + count) % DEPTH;
            store[slot] = c.value;
            count++;
            if (count % 2 == 1) odd_sum = odd_sum + c.value;
            else                even_sum = even_sum + c.value;
          end else begin
            // new front entry renumbers everything behind it
            front_idx        = (front_idx + DEPTH - 1) % DEPTH;
            store[front_idx] = c.value;
            count++;
            held     = odd_sum;
            odd_sum  = even_sum + c.value;
            even_sum = held;
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else if (c.command == CMD_POP_BACK) begin
            slot   = (front_idx + count - 1) % DEPTH;
            popped = store[slot];
            if (count % 2 == 1) odd_sum = odd_sum - popped;
            else                even_sum = even_sum - popped;
            count--;
          end else begin
            popped    = store[front_idx];
            held      = odd_sum - popped;
            odd_sum   = even_sum;
            even_sum  = held;
            front_idx = (front_idx + 1) % DEPTH;
            count--;
          end
        end
        default: ;
      endcase
      r.popped_value      = popped;
      r.status            = st;
      r.entries           = ENTRIES_W'(count);
      r.odd_position_sum  = odd_sum;
      r.even_position_sum = even_sum;
      pending_rsp.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response with no command outstanding");
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      compare_field("popped_value", want.popped_value, got.popped_value);
      compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
      compare_field("entries", DATA_W'(want.entries), DATA_W'(got.entries));
      compare_field("odd_position_sum", want.odd_position_sum, got.odd_position_sum);
      compare_field("even_position_sum", want.even_position_sum, got.even_position_sum);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  deque_scoreboard board = new();

  deque_with_parity_sums #(.DEPTH(DEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // responses cannot be stalled, so every strobe is checked on the edge
  // that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      board.check_result(rsp_o);
    end
  end

  initial begin
    #1_000_000;
    $display("tb_deque_with_parity_sums: errors");
    $finish;
  end

  function automatic cmd_t make_cmd(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] v);
    cmd_t c;
    c.command = op;
    c.value   = v;
    return c;
  endfunction

  // idle for gap cycles with junk on the bus, then hold the command until
  // the transfer happens; start stays high on return
  task automatic drive_command(input cmd_t c, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= {CMD_W'($urandom()), DATA_W'($urandom())};
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    board.note_command(c);
  endtask

  // drop start and let every owed response come back
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return VAL_MAX;
    if (roll < 6) return VAL_MIN;
    if (roll < 8) return '0;
    if (roll < 10) return -1;
    return $urandom();
  endfunction

  // fill phases lean on pushes so full is hit, drain phases lean on pops
  // so empty is hit, mixed phases wander in between
  function automatic logic [CMD_W-1:0] pick_command(int unsigned mode);
    int unsigned roll;
    int unsigned push_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (mode == 0) ? 80 : (mode == 1) ? 15 : 45;
    if (roll < 5) return CMD_QUERY;
    if (roll < 8) return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  initial begin
    cmd_t        directed [$];
    int unsigned issued;
    int unsigned phase_left;
    int unsigned mode;
    bit          no_idle;

    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty pops, query and unused code, sum wrap at both extremes, front pushes
    // swapping parity, emptied from both ends, then a front push, unused code and back pop
    directed.push_back(make_cmd(CMD_POP_BACK, VAL_MAX));
    directed.push_back(make_cmd(CMD_POP_FRONT, VAL_MIN));
    directed.push_back(make_cmd(CMD_QUERY, -1));
    directed.push_back(make_cmd(CMD_LAST_UNUSED, VAL_MAX));
    directed.push_back(make_cmd(CMD_PUSH_BACK, VAL_MAX));
    directed.push_back(make_cmd(CMD_PUSH_BACK, 1));
    directed.push_back(make_cmd(CMD_PUSH_BACK, VAL_MAX));
    directed.push_back(make_cmd(CMD_PUSH_FRONT, VAL_MIN));
    directed.push_back(make_cmd(CMD_PUSH_FRONT, -1));
    directed.push_back(make_cmd(CMD_QUERY, '0));
    directed.push_back(make_cmd(CMD_POP_FRONT, '0));
    directed.push_back(make_cmd(CMD_POP_BACK, '0));
    directed.push_back(make_cmd(CMD_POP_FRONT, '0));
    directed.push_back(make_cmd(CMD_POP_BACK, '0));
    directed.push_back(make_cmd(CMD_POP_BACK, '0));
    directed.push_back(make_cmd(CMD_POP_FRONT, '0));
    directed.push_back(make_cmd(CMD_PUSH_FRONT, '0));
    directed.push_back(make_cmd(CMD_FIRST_UNUSED, '0));
    directed.push_back(make_cmd(CMD_POP_BACK, '0));
    foreach (directed[i]) drive_command(directed[i], 0);

    // hold off until the block has answered everything
    wait_drained();

    issued     = 0;
    phase_left = 0;
    mode       = 0;
    no_idle    = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        mode       = $urandom_range(0, 2);
        no_idle    = ($urandom_range(0, 3) == 0);
      end
      drive_command(make_cmd(pick_command(mode), pick_value()), pick_gap(no_idle));
      phase_left--;
      issued++;
      if (issued % DRAIN_INTERVAL == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("tb_deque_with_parity_sums: clean");
    end else begin
      $display("tb_deque_with_parity_sums: errors");
    end
    $finish;
  end

endmodule
